/* rtl/core/dcb_pkg.sv */
package dcb_pkg;

    localparam int CHANNELS    = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int SHIFT       = SAMPLE_BITS - 1;
    localparam int ACC_BITS    = 2 * SAMPLE_BITS;
    localparam int Y_BITS      = SAMPLE_BITS + 1;
    localparam int CHAN_BITS   = 3;
    localparam int COEF_BITS   = 16;
    localparam int ADDR_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_BITS   = COEF_BITS + 1 + Y_BITS;

    localparam int QDEPTH      = 3;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    localparam logic [PADDR_BITS-3:0] REG_COEFFICIENT = '0;

    typedef struct packed {
        logic [ACC_BITS-1:0]    acc;
        logic [SAMPLE_BITS-1:0] xin;
        logic [Y_BITS-1:0]      y;
    } t_state;

    localparam int STATE_BITS = $bits(t_state);

    typedef struct packed {
        logic [CHAN_BITS-1:0]   ch;
        logic [SAMPLE_BITS-1:0] sample;
    } t_result;

    function automatic logic [SAMPLE_BITS-1:0] saturate(input logic [Y_BITS-1:0] y);
        logic [SAMPLE_BITS-1:0] res;
        case (y[Y_BITS-1:Y_BITS-2])
            2'b10:   res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2'b01:   res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            default: res = y[SAMPLE_BITS-1:0];
        endcase
        return res;
    endfunction

endpackage

/* rtl/core/dcb_ram.sv */
module dcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dc_blocking_filter.sv */
// Per-channel one-pole DC blocker.
// Input channel: i_valid/o_ready beat carries i_channel and i_sample_in.
// Output channel: o_valid/i_ready beat carries o_channel_out and o_sample_out,
// one result beat per input beat, in input order.
// Config: APB write of the UQ1.15 coefficient at address 0; read returns it.
// Path: an accepted beat is registered with its channel state read from RAM,
// then its result is written into the result queue, which presents it.
// Throughput: one beat per cycle while o_ready is high, same channel included.
// Channel state (accumulator, last input, last output) sits in one RAM with a
// registered read; the update of a channel is read at acceptance, computed and
// written back on the next edge, with a bypass for a write that lands on the
// same edge as the read. The multiply-add loop on one channel sets the clock.
// Reset clears the coefficient and per-channel valid flags (a channel not yet
// written reads as zero state), so no clearing pass is needed.
// A stalled receiver fills a three-entry result queue; o_ready drops while
// the queue plus the item in flight would overflow it.
module dc_blocking_filter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [dcb_pkg::CHAN_BITS-1:0]          i_channel,
    input  logic signed [dcb_pkg::SAMPLE_BITS-1:0] i_sample_in,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [dcb_pkg::CHAN_BITS-1:0]          o_channel_out,
    output logic signed [dcb_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dcb_pkg::PADDR_BITS-1:0]         paddr,
    input  logic [dcb_pkg::PDATA_BITS-1:0]         pwdata,
    output logic [dcb_pkg::PDATA_BITS-1:0]         prdata,
    output logic                                   pready
);

    logic [dcb_pkg::COEF_BITS-1:0] r_coef;

    logic                              w_accept;
    logic                              r_s1_valid;
    logic [dcb_pkg::CHAN_BITS-1:0]     r_s1_ch;
    logic [dcb_pkg::SAMPLE_BITS-1:0]   r_s1_x;
    logic                              w_s1_inrange;
    logic [dcb_pkg::ADDR_BITS-1:0]     w_s1_addr;

    logic [dcb_pkg::CHANNELS-1:0]      r_vld;
    logic                              r_byp_valid;
    logic [dcb_pkg::ADDR_BITS-1:0]     r_byp_addr;
    dcb_pkg::t_state                   r_byp_word;

    logic [dcb_pkg::STATE_BITS-1:0]    w_rdata;
    dcb_pkg::t_state                   w_cur;
    dcb_pkg::t_state                   w_new;
    logic                              w_we;

    logic signed [dcb_pkg::PROD_BITS-1:0] w_prod;
    logic [dcb_pkg::ACC_BITS-1:0]      w_px_old;
    logic [dcb_pkg::ACC_BITS-1:0]      w_px_new;
    logic [dcb_pkg::ACC_BITS-1:0]      w_acc;
    dcb_pkg::t_result                  w_res;

    dcb_pkg::t_result                  r_q [dcb_pkg::QDEPTH];
    logic [dcb_pkg::QPTR_BITS-1:0]     r_wp;
    logic [dcb_pkg::QPTR_BITS-1:0]     r_rp;
    logic [dcb_pkg::QCNT_BITS-1:0]     r_cnt;
    logic [dcb_pkg::QCNT_BITS-1:0]     n_cnt;
    logic                              w_pop;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (psel && penable && pwrite &&
                     paddr[dcb_pkg::PADDR_BITS-1:2] == dcb_pkg::REG_COEFFICIENT) begin
            r_coef <= pwdata[dcb_pkg::COEF_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[dcb_pkg::PADDR_BITS-1:2] == dcb_pkg::REG_COEFFICIENT) begin
            prdata = dcb_pkg::PDATA_BITS'(r_coef);
        end
    end

    // input stage
    assign o_ready  = ({1'b0, r_cnt} + {{dcb_pkg::QCNT_BITS{1'b0}}, r_s1_valid})
                      <= (dcb_pkg::QCNT_BITS + 1)'(dcb_pkg::QDEPTH - 1);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        if (w_accept) begin
            r_s1_ch <= i_channel;
            r_s1_x  <= i_sample_in;
        end
    end

    dcb_ram #(
        .WIDTH (dcb_pkg::STATE_BITS),
        .DEPTH (dcb_pkg::CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_s1_addr),
        .i_wdata (w_new),
        .i_re    (w_accept),
        .i_raddr (i_channel[dcb_pkg::ADDR_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    // compute and write back
    assign w_s1_inrange = ({1'b0, r_s1_ch} < (dcb_pkg::CHAN_BITS + 1)'(dcb_pkg::CHANNELS));
    assign w_s1_addr    = r_s1_ch[dcb_pkg::ADDR_BITS-1:0];
    assign w_we         = r_s1_valid && w_s1_inrange;

    always_comb begin
        if (r_byp_valid && r_byp_addr == w_s1_addr) begin
            w_cur = r_byp_word;
        end else if (r_vld[w_s1_addr]) begin
            w_cur = w_rdata;
        end else begin
            w_cur = '0;
        end
    end

    assign w_prod   = $signed({1'b0, r_coef}) * $signed(w_cur.y);
    assign w_px_old = dcb_pkg::ACC_BITS'($signed(w_cur.xin)) << dcb_pkg::SHIFT;
    assign w_px_new = dcb_pkg::ACC_BITS'($signed(r_s1_x)) << dcb_pkg::SHIFT;
    assign w_acc    = w_cur.acc - w_px_old + w_px_new - w_prod[dcb_pkg::ACC_BITS-1:0];

    always_comb begin
        w_new.acc = w_acc;
        w_new.xin = r_s1_x;
        w_new.y   = w_acc[dcb_pkg::ACC_BITS-1:dcb_pkg::SHIFT];
        w_res.ch  = r_s1_ch;
        w_res.sample = w_s1_inrange ? dcb_pkg::saturate(w_new.y) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            r_byp_valid <= w_we;
            if (w_we) begin
                r_vld[w_s1_addr] <= 1'b1;
            end
        end
        r_byp_addr <= w_s1_addr;
        r_byp_word <= w_new;
    end

    // result queue
    assign o_valid       = (r_cnt != '0);
    assign w_pop         = o_valid && i_ready;
    assign o_channel_out = r_q[r_rp].ch;
    assign o_sample_out  = r_q[r_rp].sample;

    always_comb begin
        n_cnt = r_cnt;
        if (r_s1_valid && !w_pop) begin
            n_cnt = r_cnt + dcb_pkg::QCNT_BITS'(1);
        end else if (!r_s1_valid && w_pop) begin
            n_cnt = r_cnt - dcb_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (r_s1_valid) begin
                r_wp <= (r_wp == dcb_pkg::QPTR_BITS'(dcb_pkg::QDEPTH - 1))
                        ? '0 : r_wp + dcb_pkg::QPTR_BITS'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == dcb_pkg::QPTR_BITS'(dcb_pkg::QDEPTH - 1))
                        ? '0 : r_rp + dcb_pkg::QPTR_BITS'(1);
            end
        end
        if (r_s1_valid) begin
            r_q[r_wp] <= w_res;
        end
    end

endmodule
